### hdl/atpc_pkg.sv
// Shared types and constants of the averaged two-point pH calibration block.
package atpc_pkg;

   // Field widths of the stream items and the registers.
   localparam int SAMPLE_W   = 12;
   localparam int VOLT_W     = 12;
   localparam int PH_W       = 14;
   localparam int PHOUT_W    = 27;
   localparam int AVG_W      = 12;
   localparam int MV_W       = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Shared divider: dividend and quotient width, divisor width.
   localparam int DIV_W = 27;
   localparam int DSR_W = 12;

   // Width of the average scaled by the reference voltage.
   localparam int PROD_W = 24;

   // Full-scale converter code, used for sizing the running sum.
   localparam int ADC_MAX = 4095;

   // Scaling constants.
   localparam logic [MV_W-1:0]  VREF_MV  = 12'd3300;
   localparam logic [DSR_W-1:0] ADC_FULL = 12'd4095;

   // Register values after reset.
   localparam logic [VOLT_W-1:0] VOLT_ONE_RST = 12'd2054;
   localparam logic [PH_W-1:0]   PH_ONE_RST   = 14'd4000;
   localparam logic [VOLT_W-1:0] VOLT_TWO_RST = 12'd1542;
   localparam logic [PH_W-1:0]   PH_TWO_RST   = 14'd6860;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOLT_ONE = 2'd0,
      REG_PH_ONE   = 2'd1,
      REG_VOLT_TWO = 2'd2,
      REG_PH_TWO   = 2'd3
   } csr_index_type;

   // Calibration point set.
   typedef struct packed {
      logic [VOLT_W-1:0] volt_one;
      logic [PH_W-1:0]   ph_one;
      logic [VOLT_W-1:0] volt_two;
      logic [PH_W-1:0]   ph_two;
   } cal_type;

   // Request to the shared divider.
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   // Status and result of the shared divider.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hdl/atpc_acc.sv
// Front end: accepts samples and accumulates each block into one sum.
module atpc_acc #(
   parameter int SAMPLES = 16,
   parameter int SUM_W   = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [atpc_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                          queue_full,
   output logic                          push,
   output logic [SUM_W-1:0]              push_sum
);
   import atpc_pkg::*;

   localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, last;

   // An item is only taken while the queue can hold a finished sum.
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign last     = (count_ff == LAST_CNT);

   // Next sum and count; the block closes on its last sample.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_ff + SUM_W'(in_sample);
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign push     = accept && last;
   assign push_sum = sum_ff + SUM_W'(in_sample);

   // Accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   // A closed block must never be pushed into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("sum pushed into a full queue");
`endif

endmodule

### hdl/atpc_queue.sv
// Short queue of block sums between the front end and the back end.
module atpc_queue #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);
   import atpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   // Popping an empty queue would hand the back end a stale sum.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");
`endif

endmodule

### hdl/atpc_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
module atpc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  atpc_pkg::div_req_type req,
   output atpc_pkg::div_rsp_type rsp
);
   import atpc_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  work_ff, work_in;
   logic [DSR_W-1:0]  rem_ff, rem_in, dsr_ff;
   logic [DSR_W:0]    trial;
   logic              fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, work_ff[DIV_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      rem_in  = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
      work_in = {work_ff[DIV_W-2:0], fits};
   end

   // Iteration control; the quotient builds up in the dividend register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         // The last step of a division raises done for one cycle.
         done_ff <= busy_ff && !req.start && (step_ff == STEP_W'(DIV_W - 1));
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            work_ff <= req.dividend;
            rem_ff  <= '0;
            dsr_ff  <= req.divisor;
         end else if (busy_ff) begin
            work_ff <= work_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = work_ff;

`ifndef SYNTHESIS
   // A new division must not start over one still in progress.
   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

### hdl/atpc_calc.sv
// Back end: turns a block sum into mean, millivolts and calibrated pH.
module atpc_calc #(
   parameter int SAMPLES = 16,
   parameter int SUM_W   = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  atpc_pkg::cal_type               cal,
   input  logic                            queue_not_empty,
   input  logic [SUM_W-1:0]                queue_head,
   output logic                            pop,
   output atpc_pkg::div_req_type           div_req,
   input  atpc_pkg::div_rsp_type           div_rsp,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [atpc_pkg::PHOUT_W-1:0] out_ph,
   output logic [atpc_pkg::AVG_W-1:0]      out_avg,
   output logic [atpc_pkg::MV_W-1:0]       out_mv,
   output logic                            out_fault
);
   import atpc_pkg::*;

   localparam int NUM_W = VOLT_W + PH_W + 2;
   localparam int SUMPH_W = PHOUT_W + 2;
   localparam logic signed [SUMPH_W-1:0] PH_HI = SUMPH_W'(2**(PHOUT_W-1) - 1);
   localparam logic signed [SUMPH_W-1:0] PH_LO = -SUMPH_W'(2**(PHOUT_W-1));

   // Reciprocal of SAMPLES, exact for every sum of up to 256 full-scale samples.
   localparam int     AVG_SHIFT   = 28;
   localparam int     AVG_RCP_W   = AVG_SHIFT + 1;
   localparam longint AVG_RCP_VAL = ((longint'(1) << AVG_SHIFT) + longint'(SAMPLES) - 1)
                                    / longint'(SAMPLES);
   localparam logic [AVG_RCP_W-1:0] AVG_RCP = AVG_RCP_W'(AVG_RCP_VAL);
   localparam int     AVG_PROD_W  = SUM_W + AVG_RCP_W;

   // Reciprocal of the full-scale code, exact for every scaled mean.
   localparam int     MV_SHIFT    = 36;
   localparam int     MV_RCP_W    = MV_SHIFT - DSR_W + 1;
   localparam longint MV_RCP_VAL  = ((longint'(1) << MV_SHIFT) + longint'(ADC_FULL) - 1)
                                    / longint'(ADC_FULL);
   localparam logic [MV_RCP_W-1:0] MV_RCP = MV_RCP_W'(MV_RCP_VAL);
   localparam int     MV_PROD_W   = PROD_W + MV_RCP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AVG_DIV,
      S_MV_MUL,
      S_MV_DIV,
      S_PH_MUL,
      S_PH_DIV,
      S_OUT
   } state_type;

   state_type              state_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [AVG_W-1:0]       avg_ff;
   logic [MV_W-1:0]        mv_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [DIV_W-1:0]       mag_ff;
   logic [DSR_W-1:0]       dvmag_ff;
   logic                   neg_ff;
   logic                   fault_ff;
   logic signed [PHOUT_W-1:0] ph_ff;
   logic                   out_valid_ff;
   logic                   ph_start_ff;

   logic [AVG_PROD_W-1:0]    avg_prod;
   logic [MV_PROD_W-1:0]     mv_prod;
   logic signed [VOLT_W:0]   dvolt, dv;
   logic signed [PH_W:0]     dph;
   logic signed [NUM_W-1:0]  num;
   logic [NUM_W-1:0]         num_mag;
   logic [VOLT_W:0]          dv_mag;
   logic signed [DIV_W:0]    q_signed;
   logic signed [SUMPH_W-1:0] ph_sum;
   logic signed [PHOUT_W-1:0] ph_sat;
   logic                     out_free;

   assign out_free = !out_valid_ff || out_ready;
   assign pop      = (state_ff == S_IDLE) && queue_not_empty;

   // Divider request for the interpolation slope.
   always_comb begin
      div_req = '0;
      if (ph_start_ff) begin
         div_req.start    = 1'b1;
         div_req.dividend = mag_ff;
         div_req.divisor  = dvmag_ff;
      end
   end

   // Constant divisions done as multiplication by a rounded-up reciprocal.
   assign avg_prod = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RCP);
   assign mv_prod  = MV_PROD_W'(prod_ff) * MV_PROD_W'(MV_RCP);

   // Interpolation terms: voltage offset times pH span over voltage span.
   always_comb begin
      dvolt   = $signed({1'b0, mv_ff}) - $signed({1'b0, cal.volt_one});
      dph     = $signed({1'b0, cal.ph_two}) - $signed({1'b0, cal.ph_one});
      dv      = $signed({1'b0, cal.volt_two}) - $signed({1'b0, cal.volt_one});
      num     = NUM_W'(dvolt) * NUM_W'(dph);
      num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dv_mag  = dv[VOLT_W] ? (VOLT_W+1)'(-dv) : (VOLT_W+1)'(dv);
   end

   // Signed quotient added to the first buffer's pH, clipped to the output range.
   always_comb begin
      q_signed = neg_ff ? -$signed({1'b0, div_rsp.quotient})
                        : $signed({1'b0, div_rsp.quotient});
      ph_sum   = $signed({{(SUMPH_W-PH_W){1'b0}}, cal.ph_one})
               + SUMPH_W'(q_signed);
      if (ph_sum > PH_HI) begin
         ph_sat = PHOUT_W'(PH_HI);
      end else if (ph_sum < PH_LO) begin
         ph_sat = PHOUT_W'(PH_LO);
      end else begin
         ph_sat = PHOUT_W'(ph_sum);
      end
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         ph_start_ff  <= 1'b0;
      end else begin
         out_valid_ff <= (out_valid_ff && !out_ready) || (state_ff == S_OUT && out_free);
         ph_start_ff  <= (state_ff == S_PH_MUL) && (dv != '0);
         unique case (state_ff)
            S_IDLE: begin
               if (queue_not_empty) begin
                  sum_ff   <= queue_head;
                  state_ff <= S_AVG_DIV;
               end
            end
            S_AVG_DIV: begin
               avg_ff   <= avg_prod[AVG_SHIFT +: AVG_W];
               state_ff <= S_MV_MUL;
            end
            S_MV_MUL: begin
               prod_ff  <= PROD_W'(avg_ff) * PROD_W'(VREF_MV);
               state_ff <= S_MV_DIV;
            end
            S_MV_DIV: begin
               mv_ff    <= mv_prod[MV_SHIFT +: MV_W];
               state_ff <= S_PH_MUL;
            end
            S_PH_MUL: begin
               if (dv == '0) begin
                  fault_ff <= 1'b1;
                  ph_ff    <= PHOUT_W'(cal.ph_one);
                  state_ff <= S_OUT;
               end else begin
                  fault_ff <= 1'b0;
                  mag_ff   <= num_mag[DIV_W-1:0];
                  dvmag_ff <= dv_mag[DSR_W-1:0];
                  neg_ff   <= num[NUM_W-1] ^ dv[VOLT_W];
                  state_ff <= S_PH_DIV;
               end
            end
            S_PH_DIV: begin
               if (div_rsp.done) begin
                  ph_ff    <= ph_sat;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  out_ph    <= ph_ff;
                  out_avg   <= avg_ff;
                  out_mv    <= mv_ff;
                  out_fault <= fault_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign out_valid = out_valid_ff;

`ifndef SYNTHESIS
   // The divider only finishes while the sequencer waits on it.
   a_done_in_wait_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_PH_DIV))
      else $error("divider result arrived outside a wait state");

   // A sum is only taken from the queue while the divider is free.
   a_pop_divider_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> !div_rsp.busy)
      else $error("new block started while the divider is busy");

   // A result is loaded only when the output register is free or being emptied.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_valid_ff && !out_ready) |=> $stable(out_ph))
      else $error("pending result overwritten");
`endif

endmodule

### hdl/averaged_two_point_ph_calibration.sv
// Top level of the averaged two-point pH calibration block.
//
// Samples enter on the req_ stream at up to one item per clock while the internal queue of
// block sums has room. Every SAMPLES items the block sum is queued and a back end works
// out the truncated mean, the mean in millivolts (mean*3300/4095) and pH times 1000 by
// two-point interpolation between the calibration points in the csr_ registers, with the
// slope division truncated toward zero. Equal calibration voltages set the fault flag on
// rsp_tuser and report the first buffer's pH. The mean and the millivolt scaling are
// reciprocal multiplications; the slope division runs on a 27-step divider at one quotient
// bit per cycle. The back end works on one block sum at a time, and the two-entry queue
// and the result register let the front end keep taking items meanwhile.
// Calibration registers should be written only while no block is in progress.
module averaged_two_point_ph_calibration #(
   parameter int SAMPLES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [atpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Sample stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // adc_sample[11:0], zero fill
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [55:0]                     rsp_tdata,  // ph_milli, average_count,
                                                       // millivolts, zero fill
   output logic                            rsp_tuser   // cal_fault
);
   import atpc_pkg::*;

   localparam int SUM_W = $clog2(SAMPLES * ADC_MAX + 1);
   localparam int QUEUE_DEPTH = 2;

   cal_type          cal_ff;
   logic             push, queue_full, queue_not_empty, pop;
   logic [SUM_W-1:0] push_sum, queue_head;
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic signed [PHOUT_W-1:0] ph;
   logic [AVG_W-1:0] avg;
   logic [MV_W-1:0]  mv;
   logic             fault;

   // Calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.volt_one <= VOLT_ONE_RST;
         cal_ff.ph_one   <= PH_ONE_RST;
         cal_ff.volt_two <= VOLT_TWO_RST;
         cal_ff.ph_two   <= PH_TWO_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_VOLT_ONE: cal_ff.volt_one <= csr_wdata[VOLT_W-1:0];
            REG_PH_ONE:   cal_ff.ph_one   <= csr_wdata[PH_W-1:0];
            REG_VOLT_TWO: cal_ff.volt_two <= csr_wdata[VOLT_W-1:0];
            REG_PH_TWO:   cal_ff.ph_two   <= csr_wdata[PH_W-1:0];
            default: ;
         endcase
      end
   end

   // Front end: block accumulation.
   atpc_acc #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[SAMPLE_W-1:0]),
      .queue_full (queue_full),
      .push       (push),
      .push_sum   (push_sum)
   );

   // Queue of finished block sums.
   atpc_queue #(
      .WIDTH (SUM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // Shared divider.
   atpc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Back end: scaling and interpolation.
   atpc_calc #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_calc (
      .clock           (clock),
      .reset           (reset),
      .cal             (cal_ff),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_ph          (ph),
      .out_avg         (avg),
      .out_mv          (mv),
      .out_fault       (fault)
   );

   assign rsp_tdata = {5'b0, mv, avg, ph};
   assign rsp_tuser = fault;

endmodule

### verif/averaged_two_point_ph_calibration_tb.sv
// Self-checking testbench for the averaged two-point pH calibration block.
module averaged_two_point_ph_calibration_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import atpc_pkg::*;

   localparam int          BLOCK_LEN    = 16;
   localparam int          NUM_PHASES   = 10;
   localparam int          BLOCKS_EACH  = 6;
   localparam int          SETTLE_LEN   = 120;
   localparam int          HOLD_LEN     = 2000;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam longint      PH_TOP       = 67108863;
   localparam longint      PH_BOTTOM    = -67108864;

   // One expected reading, as carried on the result stream.
   typedef struct packed {
      logic [PHOUT_W-1:0] ph_milli;
      logic [AVG_W-1:0]   average;
      logic [MV_W-1:0]    millivolts;
      logic               cal_fault;
   } ph_reading_type;

   // One set of calibration register values, as written on the port.
   typedef struct {
      logic [CSR_DATA_W-1:0] volt_one;
      logic [CSR_DATA_W-1:0] ph_one;
      logic [CSR_DATA_W-1:0] volt_two;
      logic [CSR_DATA_W-1:0] ph_two;
   } cal_setting_type;

   // Shapes of sample blocks used by the stimulus.
   typedef enum int {
      MIX_ZERO,
      MIX_FULL,
      MIX_EXTREMES,
      MIX_LOW,
      MIX_RANDOM
   } sample_mix_type;

   // Tracks the calibration and the block sum, and holds the readings still due.
   class ph_scoreboard;
      logic [VOLT_W-1:0] volt_one;
      logic [PH_W-1:0]   ph_one;
      logic [VOLT_W-1:0] volt_two;
      logic [PH_W-1:0]   ph_two;
      logic [19:0]       block_sum;
      int unsigned       block_count;
      ph_reading_type    readings_due[$];
      int unsigned       mismatches;

      function new();
         volt_one    = VOLT_ONE_RST;
         ph_one      = PH_ONE_RST;
         volt_two    = VOLT_TWO_RST;
         ph_two      = PH_TWO_RST;
         block_sum   = '0;
         block_count = 0;
         mismatches  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_VOLT_ONE: volt_one = value[VOLT_W-1:0];
            REG_PH_ONE:   ph_one   = value[PH_W-1:0];
            REG_VOLT_TWO: volt_two = value[VOLT_W-1:0];
            REG_PH_TWO:   ph_two   = value[PH_W-1:0];
            default: ;
         endcase
      endfunction

      // Mean, millivolts and interpolated pH of a finished block.
      function ph_reading_type predict_reading(logic [19:0] total);
         ph_reading_type r;
         longint         avg, mv, dv, ph;
         avg = longint'(total) / BLOCK_LEN;
         mv  = (avg * 3300) / 4095;
         dv  = longint'(volt_two) - longint'(volt_one);
         if (dv == 0) begin
            ph          = longint'(ph_one);
            r.cal_fault = 1'b1;
         end else begin
            // Integer division of signed values truncates toward zero.
            ph = longint'(ph_one)
                 + ((mv - longint'(volt_one)) * (longint'(ph_two) - longint'(ph_one))) / dv;
            if (ph > PH_TOP) ph = PH_TOP;
            if (ph < PH_BOTTOM) ph = PH_BOTTOM;
            r.cal_fault = 1'b0;
         end
         r.ph_milli   = ph[PHOUT_W-1:0];
         r.average    = avg[AVG_W-1:0];
         r.millivolts = mv[MV_W-1:0];
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample);
         block_sum = block_sum + 20'(sample);
         if (block_count + 1 < BLOCK_LEN) begin
            block_count++;
         end else begin
            readings_due.push_back(predict_reading(block_sum));
            block_sum   = '0;
            block_count = 0;
         end
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_reading(logic [55:0] data, logic fault);
         ph_reading_type want;
         if (readings_due.size() == 0) begin
            report_mismatch("unexpected reading, ph_milli",
                            longint'($signed(data[26:0])), 0);
         end else begin
            want = readings_due.pop_front();
            if (data[26:0] !== want.ph_milli)
               report_mismatch("ph_milli", longint'($signed(data[26:0])),
                               longint'($signed(want.ph_milli)));
            if (data[38:27] !== want.average)
               report_mismatch("average_count", longint'(data[38:27]),
                               longint'(want.average));
            if (data[50:39] !== want.millivolts)
               report_mismatch("millivolts", longint'(data[50:39]),
                               longint'(want.millivolts));
            if (data[55:51] !== 5'd0)
               report_mismatch("zero fill", longint'(data[55:51]), 0);
            if (fault !== want.cal_fault)
               report_mismatch("cal_fault", longint'(fault), longint'(want.cal_fault));
         end
      endtask

      function int pending();
         return readings_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;   // adc_sample[11:0], zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;        // ph_milli, average_count, millivolts, zero fill
   logic                  rsp_tuser;        // cal_fault

   ph_scoreboard sb;
   bit           steady = 1'b0;
   bit           hold_done = 1'b0;
   int unsigned  readings_seen = 0;
   int unsigned  cycles = 0;

   averaged_two_point_ph_calibration #(
      .SAMPLES(BLOCK_LEN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Watch both streams: accepted items feed the predictor, readings are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata[SAMPLE_W-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_reading(rsp_tdata, rsp_tuser);
            readings_seen++;
         end
      end
   end

   // Result side: random stalls, one long hold-off early on, none at the end.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (steady) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!hold_done && readings_seen >= 2) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Offer one item and wait until it is taken; the valid stays high afterwards.
   task automatic send_sample(logic [SAMPLE_W-1:0] sample);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic program_cal(cal_setting_type s);
      csr_write(REG_VOLT_ONE, s.volt_one);
      csr_write(REG_PH_ONE, s.ph_one);
      csr_write(REG_VOLT_TWO, s.volt_two);
      csr_write(REG_PH_TWO, s.ph_two);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every reading due, then let the back end drain.
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   // Calibration of each phase: the extremes first, then random ones.
   function automatic cal_setting_type pick_setting(int unsigned phase);
      cal_setting_type s;
      case (phase)
         1: s = '{14'd0, 14'd0, 14'd0, 14'd0};
         2: s = '{14'd4095, 14'd16383, 14'd4095, 14'd16383};
         3: s = '{14'd0, 14'd0, 14'd4095, 14'd16383};
         4: s = '{14'd4095, 14'd16383, 14'd0, 14'd0};
         5: s = '{14'd0, 14'd16383, 14'd1, 14'd0};
         6: s = '{14'd3300, 14'd0, 14'd3299, 14'd14000};
         7: s = '{14'd1000, 14'd7000, 14'd1000, 14'd2000};
         8: s = '{14'($urandom_range(0, 3300)), 14'($urandom_range(0, 14000)),
                  14'($urandom_range(0, 3300)), 14'($urandom_range(0, 14000))};
         default: s = '{14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                        14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383))};
      endcase
      // The top two bits of a voltage write are dropped by the register.
      if (phase <= 7) begin
         s.volt_one[13:12] = 2'($urandom_range(0, 3));
         s.volt_two[13:12] = 2'($urandom_range(0, 3));
      end
      return s;
   endfunction

   function automatic logic [SAMPLE_W-1:0] make_sample(sample_mix_type mix);
      case (mix)
         MIX_ZERO:     return '0;
         MIX_FULL:     return 12'd4095;
         MIX_EXTREMES: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
         MIX_LOW:      return 12'($urandom_range(0, 31));
         default:      return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Stimulus: a full-scale and a zero block under reset calibration, then random
   // blocks across a series of calibration settings.
   initial begin
      int unsigned    phase, blk, k, pick;
      sample_mix_type mix;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == NUM_PHASES - 1)
            steady = 1'b1;
         if (phase != 0) begin
            settle();
            program_cal(pick_setting(phase));
         end
         for (blk = 0; blk < BLOCKS_EACH; blk++) begin
            pick = $urandom_range(0, 7);
            mix  = (pick > MIX_RANDOM) ? MIX_RANDOM : sample_mix_type'(pick);
            if (phase == 0 && blk == 0) mix = MIX_FULL;
            if (phase == 0 && blk == 1) mix = MIX_ZERO;
            for (k = 0; k < BLOCK_LEN; k++) begin
               send_sample(make_sample(mix));
               if (!steady && !(blk == BLOCKS_EACH - 1 && k == BLOCK_LEN - 1)
                   && $urandom_range(0, 4) == 0) begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 19)) @(posedge clock);
               end
            end
         end
         req_tvalid <= 1'b0;
      end
      settle();
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
